// File: hdl/pip_pkg.sv
// shared types and constants for the point in polygon test
package pip_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int OPND_COUNT     = 8;

  typedef struct packed {
    logic first;
    logic last;
    logic enough;
    logic cross_a;
    logic up_a;
    logic cross_b;
    logic up_b;
  } edge_ctl_t;

endpackage

// File: hdl/pip_front.sv
// front end: takes vertex words, holds polygon state, forms edge operands
module pip_front #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic signed [COORD_BITS-1:0]                        query_x,
  input  logic signed [COORD_BITS-1:0]                        query_y,
  input  logic signed [COORD_BITS-1:0]                        vertex_x,
  input  logic signed [COORD_BITS-1:0]                        vertex_y,
  input  logic                                                first_vertex,
  input  logic                                                last_vertex,
  input  logic                                                in_valid,
  output logic                                                in_stall,
  input  logic                                                q_full,
  output logic                                                q_push,
  output pip_pkg::edge_ctl_t                                  q_ctl,
  output logic [pip_pkg::OPND_COUNT*(COORD_BITS+1)-1:0]       q_opnd
);
  import pip_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam logic [1:0] COUNT_ONE  = 2'd1;
  localparam logic [1:0] COUNT_FULL = 2'd3;

  logic signed [COORD_BITS-1:0] held_query_x, held_query_y;
  logic signed [COORD_BITS-1:0] start_x, start_y;
  logic signed [COORD_BITS-1:0] previous_x, previous_y;
  logic [1:0]                   vertex_count;
  logic [1:0]                   vertex_count_next;

  logic signed [COORD_BITS-1:0] cur_qx, cur_qy, cur_sx, cur_sy;
  logic signed [D-1:0]          qx_e, qy_e, sx_e, sy_e, vx_e, vy_e, px_e, py_e;
  logic                         accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept;

  assign cur_qx = first_vertex ? query_x  : held_query_x;
  assign cur_qy = first_vertex ? query_y  : held_query_y;
  assign cur_sx = first_vertex ? vertex_x : start_x;
  assign cur_sy = first_vertex ? vertex_y : start_y;

  assign qx_e = {cur_qx[COORD_BITS-1], cur_qx};
  assign qy_e = {cur_qy[COORD_BITS-1], cur_qy};
  assign sx_e = {cur_sx[COORD_BITS-1], cur_sx};
  assign sy_e = {cur_sy[COORD_BITS-1], cur_sy};
  assign vx_e = {vertex_x[COORD_BITS-1], vertex_x};
  assign vy_e = {vertex_y[COORD_BITS-1], vertex_y};
  assign px_e = {previous_x[COORD_BITS-1], previous_x};
  assign py_e = {previous_y[COORD_BITS-1], previous_y};

  always_comb begin
    if (first_vertex) begin
      vertex_count_next = COUNT_ONE;
    end else if (vertex_count == COUNT_FULL) begin
      vertex_count_next = COUNT_FULL;
    end else begin
      vertex_count_next = vertex_count + 2'd1;
    end
  end

  // edge from this vertex to the previous one
  assign q_opnd[0*D +: D] = qx_e - vx_e;
  assign q_opnd[1*D +: D] = py_e - vy_e;
  assign q_opnd[2*D +: D] = px_e - vx_e;
  assign q_opnd[3*D +: D] = qy_e - vy_e;
  // closing edge from the start vertex to this one
  assign q_opnd[4*D +: D] = qx_e - sx_e;
  assign q_opnd[5*D +: D] = vy_e - sy_e;
  assign q_opnd[6*D +: D] = vx_e - sx_e;
  assign q_opnd[7*D +: D] = qy_e - sy_e;

  always_comb begin
    q_ctl.first   = first_vertex;
    q_ctl.last    = last_vertex;
    q_ctl.enough  = (vertex_count_next == COUNT_FULL);
    q_ctl.cross_a = !first_vertex && ((vertex_y > cur_qy) != (previous_y > cur_qy));
    q_ctl.up_a    = previous_y > vertex_y;
    q_ctl.cross_b = last_vertex && ((cur_sy > cur_qy) != (vertex_y > cur_qy));
    q_ctl.up_b    = vertex_y > cur_sy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_query_x <= '0;
      held_query_y <= '0;
      start_x      <= '0;
      start_y      <= '0;
      previous_x   <= '0;
      previous_y   <= '0;
      vertex_count <= '0;
    end else if (accept) begin
      if (first_vertex) begin
        held_query_x <= query_x;
        held_query_y <= query_y;
        start_x      <= vertex_x;
        start_y      <= vertex_y;
      end
      previous_x   <= vertex_x;
      previous_y   <= vertex_y;
      vertex_count <= vertex_count_next;
    end
  end

endmodule

// File: hdl/pip_queue.sv
// two-word queue between front and back
module pip_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/pip_back.sv
// back end: cross products, crossing compare, parity and result register
module pip_back #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_empty,
  input  pip_pkg::edge_ctl_t                            q_ctl,
  input  logic [pip_pkg::OPND_COUNT*(COORD_BITS+1)-1:0] q_opnd,
  output logic                                          q_pop,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic                                          inside_res
);
  import pip_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  logic signed [D-1:0] a_l, a_dy, a_r1, a_r2, b_l, b_dy, b_r1, b_r2;
  logic signed [P-1:0] prod_al, prod_ar, prod_bl, prod_br;
  edge_ctl_t           m_ctl;
  logic                m_vld;
  logic                parity;
  logic                parity_next;
  logic                m_adv, m_load_ok, out_free;
  logic                lt_a, lt_b;

  assign a_l  = q_opnd[0*D +: D];
  assign a_dy = q_opnd[1*D +: D];
  assign a_r1 = q_opnd[2*D +: D];
  assign a_r2 = q_opnd[3*D +: D];
  assign b_l  = q_opnd[4*D +: D];
  assign b_dy = q_opnd[5*D +: D];
  assign b_r1 = q_opnd[6*D +: D];
  assign b_r2 = q_opnd[7*D +: D];

  assign out_free  = !out_valid || !out_stall;
  assign m_adv     = m_vld && (!m_ctl.last || out_free);
  assign m_load_ok = !m_vld || m_adv;
  assign q_pop     = m_load_ok && !q_empty;

  // compare direction follows the sign of dy
  assign lt_a = m_ctl.up_a ? (prod_al < prod_ar) : (prod_ar < prod_al);
  assign lt_b = m_ctl.up_b ? (prod_bl < prod_br) : (prod_br < prod_bl);

  assign parity_next = (m_ctl.first ? 1'b0 : parity)
                     ^ (m_ctl.cross_a && lt_a)
                     ^ (m_ctl.cross_b && lt_b);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_ctl   <= q_ctl;
      prod_al <= a_l * a_dy;
      prod_ar <= a_r1 * a_r2;
      prod_bl <= b_l * b_dy;
      prod_br <= b_r1 * b_r2;
    end
    if (m_adv && m_ctl.last) begin
      inside_res <= m_ctl.enough && parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld     <= 1'b0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_load_ok) begin
        m_vld <= !q_empty;
      end
      if (m_adv) begin
        parity <= parity_next;
      end
      if (m_adv && m_ctl.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/point_in_polygon_test.sv
// top level of the even-odd point in polygon test
// Takes one vertex word per clock while in_stall is low and gives one inside_res
// word for each word marked last_vertex once it has passed the queue and the
// product register into the result register and the output is free. The front
// end updates the held query, start and previous vertex for each accepted
// vertex; the four cross products sit in their own register stage in the back
// end, and a two-word queue lets the front accept until full while output stalls.
module point_in_polygon_test #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         first_vertex,
  input  logic                         last_vertex,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic                         inside_res,
  output logic                         out_valid,
  input  logic                         out_stall
);
  import pip_pkg::*;

  localparam int OPND_W = OPND_COUNT * (COORD_BITS + 1);
  localparam int Q_W    = $bits(edge_ctl_t) + OPND_W;

  edge_ctl_t         f_ctl, b_ctl;
  logic [OPND_W-1:0] f_opnd, b_opnd;
  logic [Q_W-1:0]    q_rdata;
  logic              q_push, q_pop, q_full, q_empty;

  pip_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .query_x     (query_x),
    .query_y     (query_y),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .first_vertex(first_vertex),
    .last_vertex (last_vertex),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctl       (f_ctl),
    .q_opnd      (f_opnd)
  );

  pip_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata({f_ctl, f_opnd}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign b_ctl  = q_rdata[Q_W-1:OPND_W];
  assign b_opnd = q_rdata[OPND_W-1:0];

  pip_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_ctl     (b_ctl),
    .q_opnd    (b_opnd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .inside_res(inside_res)
  );

`ifndef SYNTH
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !q_empty)
    else $error("queue empty after a word was accepted");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (q_full && !q_pop) |=> q_full)
    else $error("full queue drained without a pop");
`endif

endmodule
